[design/sdt_pkg.sv]
package sdt_pkg;

  localparam int MaxSpeakersDefault = 6;
  localparam int LedCountDefault = 18;
  localparam int Slots = 8;
  localparam int HalfTurn = 23040;
  localparam int FullTurn = 46080;

  // ceil(2^37 / 46080), exact floor division of products below 2^21
  localparam longint LedRecip = 64'd2982617;
  localparam int LedShift = 37;

  localparam logic [2:0] KIND_NEW = 3'd0;
  localparam logic [2:0] KIND_MATCHED = 3'd1;
  localparam logic [2:0] KIND_OVERLAP = 3'd2;
  localparam logic [2:0] KIND_FULL = 3'd3;
  localparam logic [2:0] KIND_LOW = 3'd4;
  localparam logic [2:0] KIND_LED = 3'd5;
  localparam logic [2:0] KIND_EMPTY = 3'd6;

  localparam logic [1:0] REG_SPREAD = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_BRIGHT = 2'd2;

  function automatic logic signed [24:0] atan_entry(input logic [3:0] i);
    case (i)
      4'd0: atan_entry = 25'sd92160;
      4'd1: atan_entry = 25'sd54405;
      4'd2: atan_entry = 25'sd28746;
      4'd3: atan_entry = 25'sd14592;
      4'd4: atan_entry = 25'sd7324;
      4'd5: atan_entry = 25'sd3666;
      4'd6: atan_entry = 25'sd1833;
      4'd7: atan_entry = 25'sd917;
      4'd8: atan_entry = 25'sd458;
      4'd9: atan_entry = 25'sd229;
      4'd10: atan_entry = 25'sd115;
      4'd11: atan_entry = 25'sd57;
      4'd12: atan_entry = 25'sd29;
      4'd13: atan_entry = 25'sd14;
      4'd14: atan_entry = 25'sd7;
      default: atan_entry = 25'sd4;
    endcase
  endfunction

  function automatic logic [11:0] colour_entry(input logic [2:0] i);
    case (i)
      3'd0: colour_entry = {4'd12, 4'd0, 4'd0};
      3'd1: colour_entry = {4'd0, 4'd12, 4'd0};
      3'd2: colour_entry = {4'd0, 4'd0, 4'd9};
      3'd3: colour_entry = {4'd6, 4'd6, 4'd0};
      3'd4: colour_entry = {4'd6, 4'd0, 4'd5};
      3'd5: colour_entry = {4'd0, 4'd6, 4'd5};
      3'd6: colour_entry = {4'd12, 4'd0, 4'd0};
      default: colour_entry = {4'd0, 4'd12, 4'd0};
    endcase
  endfunction

  function automatic logic signed [15:0] wrap16(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r > 18'sd23040) r = r - 18'sd46080;
    if (r <= -18'sd23040) r = r + 18'sd46080;
    wrap16 = r[15:0];
  endfunction

endpackage

[design/sdt_cordic.sv]
module sdt_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  output logic               done,
  output logic signed [15:0] angle
);
  import sdt_pkg::*;

  logic signed [25:0] cx;
  logic signed [25:0] cy;
  logic signed [24:0] z;
  logic [3:0] step;
  logic busy;
  logic signed [25:0] sx;
  logic signed [25:0] sy;
  logic signed [16:0] nx;
  logic signed [16:0] ny;

  assign sx = cx >>> step;
  assign sy = cy >>> step;
  assign nx = -{x_in[15], x_in};
  assign ny = -{y_in[15], y_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (x_in == 16'sd0 && y_in == 16'sd0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          step <= '0;
          if (x_in < 0) begin
            z <= (y_in >= 0) ? 25'sd368640 : -25'sd368640;
            cx <= {{1{nx[16]}}, nx, 8'd0};
            cy <= {{1{ny[16]}}, ny, 8'd0};
          end else begin
            z <= '0;
            cx <= {{2{x_in[15]}}, x_in, 8'd0};
            cy <= {{2{y_in[15]}}, y_in, 8'd0};
          end
        end
      end else if (busy) begin
        if (cy > 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
          z <= z + atan_entry(step);
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          z <= z - atan_entry(step);
        end
        step <= step + 4'd1;
        if (step == 4'd15) busy <= 1'b0;
        if (step == 4'd15) done <= 1'b1;
      end
    end
  end

  logic signed [24:0] zf;
  logic signed [24:0] zfr;
  assign zf = (cy > 0) ? z + atan_entry(step) : z - atan_entry(step);
  assign zfr = (zf + 25'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (busy && step == 4'd15) angle <= wrap16(zfr[17:0]);
    else if (start && x_in == 16'sd0 && y_in == 16'sd0) angle <= '0;
  end

endmodule

[design/sdt_divider.sv]
module sdt_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] num,
  input  logic [15:0]        den,
  output logic               done,
  output logic signed [16:0] quo
);
  logic [16:0] rem;
  logic [16:0] q;
  logic [4:0] cnt;
  logic busy;
  logic neg;
  logic [17:0] trial;

  assign trial = {rem[16:0], q[16]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        neg <= num[16];
        q <= num[16] ? 17'(-num) : 17'(num);
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial[16:0];
          q <= {q[15:0], 1'b1};
        end else begin
          rem <= {rem[15:0], q[16]};
          q <= {q[15:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);

endmodule

[design/speaker_direction_tracker.sv]
// Speaker direction tracker. Observations are matched by bearing against up
// to MAX_SPEAKERS stored talkers, and an end of frame item gives one led drive
// transfer per stored speaker, one a cycle while the receiver takes them.
// Order of work for an observation: the iterative CORDIC (which a zero vector
// skips), a scan of the stored speaker table (skipped when none is stored), a
// decision, and for a matched turn that nudges the bearing the shared
// restoring divider. A low energy item or an empty frame answers at the
// accepting edge. in_stall is high while an item is in work and while a
// result waits in the output register, so the next item is taken only once
// the previous result has been taken and the tracker is back in idle.
module speaker_direction_tracker #(
  parameter int MAX_SPEAKERS = sdt_pkg::MaxSpeakersDefault,
  parameter int LED_COUNT = sdt_pkg::LedCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0] energy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [2:0]  slot,
  output logic [4:0]  led_index,
  output logic [15:0] turn_count,
  output logic [31:0] talk_ticks,
  output logic signed [15:0] bearing,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last
);
  import sdt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DECI  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FRAME = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  localparam logic [26:0] LedMul = 27'(longint'(LED_COUNT) * LedRecip);

  state_t state;
  logic [14:0] match_window;
  logic [15:0] energy_threshold;
  logic [4:0] led_gain;

  logic [3:0] speaker_count;
  logic signed [15:0] speaker_angle [Slots];
  logic [4:0] speaker_led [Slots];
  logic [Slots-1:0] talking_now;
  logic [Slots-1:0] talked_before;
  logic [15:0] turns [Slots];
  logic [31:0] talk_time [Slots];

  logic signed [15:0] a;
  logic [2:0] idx;
  logic [3:0] hit_count;
  logic [2:0] who;
  logic signed [16:0] mdiff;
  logic frame_last;

  logic cord_start, cord_done;
  logic signed [15:0] cord_angle;
  logic div_start, div_done;
  logic signed [16:0] div_quo;

  sdt_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .x_in(pos_x), .y_in(pos_y),
    .done(cord_done), .angle(cord_angle)
  );

  sdt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(mdiff), .den(turns[who]),
    .done(div_done), .quo(div_quo)
  );

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_SPREAD: prdata = {17'd0, match_window};
      REG_THRESH: prdata = {16'd0, energy_threshold};
      REG_BRIGHT: prdata = {27'd0, led_gain};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_window <= 15'd3200;
      energy_threshold <= 16'd32768;
      led_gain <= 5'd12;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SPREAD: match_window <= pwdata[14:0];
        REG_THRESH: energy_threshold <= pwdata[15:0];
        REG_BRIGHT: led_gain <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // scan datapath
  logic signed [17:0] d_raw;
  logic signed [15:0] d_w;
  logic [15:0] d_abs;
  assign d_raw = 18'(speaker_angle[idx]) - 18'(a);
  assign d_w = wrap16(d_raw);
  assign d_abs = d_w[15] ? 16'(-d_w) : 16'(d_w);

  // led index of the observed bearing
  logic [15:0] led_d;
  logic [42:0] led_prod;
  logic [5:0] led_q;
  logic [4:0] led_new;
  assign led_d = 16'(18'sd23040 - 18'(a));
  assign led_prod = {27'd0, led_d} * {16'd0, LedMul};
  assign led_q = led_prod[LedShift +: 6];
  assign led_new = (led_q >= 6'(LED_COUNT)) ? 5'd0 : led_q[4:0];

  // colour of a frame slot
  logic [11:0] col;
  logic [8:0] cr, cg, cb;
  logic [4:0] br;
  assign col = colour_entry(idx);
  assign br = talking_now[idx] ? led_gain : 5'd0;
  assign cr = {4'd0, br} * {5'd0, col[11:8]};
  assign cg = {4'd0, br} * {5'd0, col[7:4]};
  assign cb = {4'd0, br} * {5'd0, col[3:0]};

  logic [15:0] turns_inc;
  assign turns_inc = (turns[who] < 16'hFFFF) ? turns[who] + 16'd1 : turns[who];

  assign frame_last = ({1'b0, idx} == speaker_count - 4'd1);

  assign in_stall = (state != S_IDLE) || out_valid;
  assign cord_start = (state == S_IDLE) && in_valid && !in_stall && !op &&
                      energy > energy_threshold;
  assign div_start = (state == S_DECI) && hit_count == 4'd1 && !talked_before[who];

  task automatic put(input logic [2:0] k, input logic [2:0] s, input logic [4:0] l,
                     input logic [15:0] t, input logic [31:0] tt,
                     input logic signed [15:0] b, input logic lst);
    kind <= k; slot <= s; led_index <= l; turn_count <= t; talk_ticks <= tt;
    bearing <= b; red <= '0; green <= '0; blue <= '0; last <= lst;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      speaker_count <= '0;
      talking_now <= '0;
      talked_before <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FRAME) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          idx <= '0;
          hit_count <= '0;
          if (op) begin
            if (speaker_count == 4'd0) begin
              put(KIND_EMPTY, 3'd0, 5'd0, 16'd0, 32'd0, 16'sd0, 1'b1);
              out_valid <= 1'b1;
            end else state <= S_FRAME;
          end else if (energy <= energy_threshold) begin
            put(KIND_LOW, 3'd0, 5'd0, 16'd0, 32'd0, 16'sd0, 1'b1);
            out_valid <= 1'b1;
          end else state <= S_CORD;
        end
        S_CORD: if (cord_done) begin
          a <= cord_angle;
          state <= (speaker_count == 4'd0) ? S_DECI : S_SCAN;
        end
        S_SCAN: begin
          if ({1'b0, d_abs} < {2'b00, match_window}) begin
            hit_count <= hit_count + 4'd1;
            who <= idx;
            mdiff <= 17'(d_w);
          end
          if ({1'b0, idx} == speaker_count - 4'd1) state <= S_DECI;
          else idx <= idx + 3'd1;
        end
        S_DECI: begin
          if (hit_count == 4'd0) begin
            if (speaker_count >= 4'(MAX_SPEAKERS)) begin
              put(KIND_FULL, 3'd0, led_new, 16'd0, 32'd0, a, 1'b1);
            end else begin
              speaker_angle[speaker_count[2:0]] <= a;
              speaker_led[speaker_count[2:0]] <= led_new;
              talking_now[speaker_count[2:0]] <= 1'b1;
              talked_before[speaker_count[2:0]] <= 1'b0;
              turns[speaker_count[2:0]] <= 16'd1;
              talk_time[speaker_count[2:0]] <= 32'd0;
              speaker_count <= speaker_count + 4'd1;
              put(KIND_NEW, speaker_count[2:0], led_new, 16'd1, 32'd0, a, 1'b1);
            end
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (hit_count == 4'd1) begin
            talking_now[who] <= 1'b1;
            if (talk_time[who] != 32'hFFFFFFFF) talk_time[who] <= talk_time[who] + 32'd1;
            if (!talked_before[who]) begin
              turns[who] <= turns_inc;
              state <= S_DIV;
            end else begin
              put(KIND_MATCHED, who, speaker_led[who], turns[who],
                  (talk_time[who] != 32'hFFFFFFFF) ? talk_time[who] + 32'd1 : talk_time[who],
                  speaker_angle[who], 1'b1);
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            put(KIND_OVERLAP, who, speaker_led[who], turns[who], talk_time[who],
                speaker_angle[who], 1'b1);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_DIV: if (div_done) begin
          speaker_angle[who] <= wrap16(18'(speaker_angle[who]) + 18'(div_quo));
          put(KIND_MATCHED, who, speaker_led[who], turns[who], talk_time[who],
              wrap16(18'(speaker_angle[who]) + 18'(div_quo)), 1'b1);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_FRAME: if (!out_valid || !out_stall) begin
          kind <= KIND_LED;
          slot <= idx;
          led_index <= speaker_led[idx];
          turn_count <= turns[idx];
          talk_ticks <= talk_time[idx];
          bearing <= speaker_angle[idx];
          last <= frame_last;
          red <= cr[8] ? 8'hFF : cr[7:0];
          green <= cg[8] ? 8'hFF : cg[7:0];
          blue <= cb[8] ? 8'hFF : cb[7:0];
          out_valid <= 1'b1;
          talked_before[idx] <= talking_now[idx];
          talking_now[idx] <= 1'b0;
          if (frame_last) state <= S_OUT;
          else idx <= idx + 3'd1;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    speaker_count <= 4'(MAX_SPEAKERS)) else $error("speaker count overflow");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && in_valid && !in_stall |=> in_stall)
    else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_DECI && hit_count == 4'd1)
    else $error("divider started outside single match");

endmodule

[test/tb_speaker_direction_tracker.sv]
`timescale 1ns / 100ps

module tb_speaker_direction_tracker;
  import sdt_pkg::*;

  localparam int MaxSpk = MaxSpeakersDefault;
  localparam int Leds = LedCountDefault;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic op = 0;
  logic signed [15:0] pos_x = '0, pos_y = '0;
  logic [15:0] energy = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] kind, slot;
  logic [4:0] led_index;
  logic [15:0] turn_count;
  logic [31:0] talk_ticks;
  logic signed [15:0] bearing;
  logic [7:0] red, green, blue;
  logic last;

  speaker_direction_tracker dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [4:0] led;
    logic [15:0] turns;
    logic [31:0] ticks;
    logic signed [15:0] brg;
    logic [7:0] r, g, b;
    logic last;
  } track_result_t;

  typedef struct {
    logic op;
    logic signed [15:0] x, y;
    logic [15:0] e;
    logic known;
    track_result_t want;
  } stim_row_t;

  // predictor state
  int window_q, thresh_q, gain_q;
  int spk_n;
  int spk_angle[8];
  int spk_led[8];
  bit spk_talk[8], spk_before[8];
  int spk_turns[8];
  longint spk_ticks[8];

  track_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 0;
  int quiet_cycles = 0;

  function automatic int floor_shr(int v, int s);
    return v >>> s;
  endfunction

  function automatic int wrap_bearing(int a);
    if (a > HalfTurn) a -= FullTurn;
    if (a <= -HalfTurn) a += FullTurn;
    return a;
  endfunction

  function automatic int cordic_bearing(int x, int y);
    int z, cx, cy, nx, ny;
    int tabv[16] = '{92160, 54405, 28746, 14592, 7324, 3666, 1833, 917,
                     458, 229, 115, 57, 29, 14, 7, 4};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 2048 : -180 * 2048;
      x = -x;
      y = -y;
    end
    cx = x * 256;
    cy = y * 256;
    for (int i = 0; i < 16; i++) begin
      if (cy > 0) begin
        nx = cx + floor_shr(cy, i);
        ny = cy - floor_shr(cx, i);
        z += tabv[i];
      end else begin
        nx = cx - floor_shr(cy, i);
        ny = cy + floor_shr(cx, i);
        z -= tabv[i];
      end
      cx = nx;
      cy = ny;
    end
    return wrap_bearing(floor_shr(z + 8, 4));
  endfunction

  function automatic int led_for(int a);
    longint idx;
    idx = (longint'(HalfTurn - a) * Leds) / FullTurn;
    return (idx >= Leds) ? 0 : int'(idx);
  endfunction

  function automatic track_result_t mk(int k, int s, int l, int t, longint tk, int b,
                                      int r, int g, int bl, bit lst);
    track_result_t o;
    o.kind = 3'(k); o.slot = 3'(s); o.led = 5'(l); o.turns = 16'(t); o.ticks = tk[31:0];
    o.brg = 16'(b); o.r = 8'(r); o.g = 8'(g); o.b = 8'(bl); o.last = lst;
    return o;
  endfunction

  task automatic track_predict(logic o, logic signed [15:0] x, logic signed [15:0] y,
                               logic [15:0] e);
    int a, who, hits, mdiff, d, ad, c[3];
    int ctab[6][3] = '{'{12, 0, 0}, '{0, 12, 0}, '{0, 0, 9}, '{6, 6, 0},
                       '{6, 0, 5}, '{0, 6, 5}};
    if (o) begin
      if (spk_n == 0) begin
        pending_results.push_back(mk(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        return;
      end
      for (int i = 0; i < spk_n; i++) begin
        for (int j = 0; j < 3; j++) begin
          c[j] = (spk_talk[i] ? gain_q : 0) * ctab[i % 6][j];
          if (c[j] > 255) c[j] = 255;
        end
        pending_results.push_back(mk(KIND_LED, i, spk_led[i], spk_turns[i], spk_ticks[i],
                                     spk_angle[i], c[0], c[1], c[2], i == spk_n - 1));
      end
      for (int i = 0; i < spk_n; i++) begin
        spk_before[i] = spk_talk[i];
        spk_talk[i] = 0;
      end
      return;
    end
    if (int'(e) <= thresh_q) begin
      pending_results.push_back(mk(KIND_LOW, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    a = cordic_bearing(x, y);
    hits = 0; who = 0; mdiff = 0;
    for (int i = 0; i < spk_n; i++) begin
      d = wrap_bearing(spk_angle[i] - a);
      ad = d < 0 ? -d : d;
      if (ad < window_q) begin
        hits++;
        who = i;
        mdiff = d;
      end
    end
    if (hits == 0) begin
      if (spk_n >= MaxSpk) begin
        pending_results.push_back(mk(KIND_FULL, 0, led_for(a), 0, 0, a, 0, 0, 0, 1));
        return;
      end
      spk_angle[spk_n] = a;
      spk_led[spk_n] = led_for(a);
      spk_talk[spk_n] = 1;
      spk_before[spk_n] = 0;
      spk_turns[spk_n] = 1;
      spk_ticks[spk_n] = 0;
      pending_results.push_back(mk(KIND_NEW, spk_n, spk_led[spk_n], 1, 0, a, 0, 0, 0, 1));
      spk_n++;
      return;
    end
    if (hits == 1) begin
      spk_talk[who] = 1;
      if (!spk_before[who]) begin
        if (spk_turns[who] < 65535) spk_turns[who]++;
        spk_angle[who] = wrap_bearing(spk_angle[who] + mdiff / spk_turns[who]);
      end
      if (spk_ticks[who] != 64'hFFFF_FFFF) spk_ticks[who]++;
      pending_results.push_back(mk(KIND_MATCHED, who, spk_led[who], spk_turns[who],
                                   spk_ticks[who], spk_angle[who], 0, 0, 0, 1));
      return;
    end
    pending_results.push_back(mk(KIND_OVERLAP, who, spk_led[who], spk_turns[who],
                                 spk_ticks[who], spk_angle[who], 0, 0, 0, 1));
  endtask

  task automatic apb_write(logic [1:0] idx, int val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_SPREAD: window_q = val & 16'h7FFF;
      REG_THRESH: thresh_q = val & 16'hFFFF;
      default: gain_q = val & 5'h1F;
    endcase
  endtask

  task automatic send_item(logic o, logic signed [15:0] x, logic signed [15:0] y,
                           logic [15:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; op <= o; pos_x <= x; pos_y <= y; energy <= e;
    do @(posedge clk); while (in_stall);
    track_predict(o, x, y, e);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // random frame item, low energy observation, observation near a stored speaker, or random observation
  task automatic random_item;
    int r, ang;
    real rad;
    r = $urandom_range(99);
    if (r < 15) send_item(1, 0, 0, 16'($urandom));
    else if (r < 25) send_item(0, 16'($urandom), 16'($urandom), 16'($urandom_range(thresh_q)));
    else if (r < 70 && spk_n > 0) begin
      ang = spk_angle[$urandom_range(spk_n - 1)] + $urandom_range(4000) - 2000;
      rad = ang * 3.14159265 / 23040.0;
      send_item(0, 16'($rtoi(30000.0 * $cos(rad))), 16'($rtoi(30000.0 * $sin(rad))),
                16'($urandom_range(65535, thresh_q < 65535 ? thresh_q + 1 : 65535)));
    end else send_item(0, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    track_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transfer kind %0d", $time, kind);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if ({kind, slot, led_index, turn_count, talk_ticks, bearing, red, green, blue,
             last} !== w) begin
          $display("%0t mismatch expected %h actual %h", $time, w,
                   {kind, slot, led_index, turn_count, talk_ticks, bearing, red, green,
                    blue, last});
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t rows[$];

  task automatic add_row(logic o, int x, int y, int e, bit known, track_result_t w);
    stim_row_t s;
    s.op = o; s.x = 16'(x); s.y = 16'(y); s.e = 16'(e); s.known = known; s.want = w;
    rows.push_back(s);
  endtask

  initial begin
    track_result_t none;
    none = '0;
    window_q = 3200; thresh_q = 32768; gain_q = 12;
    spk_n = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    add_row(1, 0, 0, 0, 1, mk(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(0, 32767, 0, 32768, 1, mk(KIND_LOW, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(0, 0, 0, 65535, 0, none);
    add_row(0, 0, 0, 65535, 0, none);
    add_row(1, 0, 0, 0, 0, none);
    add_row(0, 0, 0, 65535, 0, none);
    add_row(0, -32768, 0, 40000, 0, none);
    add_row(0, -32768, -32768, 40000, 0, none);
    add_row(0, 0, 32767, 40000, 0, none);
    add_row(0, 0, -32768, 65535, 0, none);
    add_row(0, 23000, 23000, 50000, 0, none);
    add_row(0, -23000, 23000, 50000, 0, none);
    add_row(0, 32767, -32768, 50000, 0, none);
    add_row(0, 100, 30000, 50000, 0, none);
    add_row(1, 0, 0, 0, 0, none);
    add_row(0, -32768, 1, 32769, 0, none);
    add_row(0, 0, 0, 0, 1, mk(KIND_LOW, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].x, rows[i].y, rows[i].e);
      if (rows[i].known && pending_results[$] !== rows[i].want) begin
        $display("%0t directed row %0d expected %h actual prediction %h", $time, i,
                 rows[i].want, pending_results[$]);
        errors++;
      end
    end
    drain;

    apb_write(REG_SPREAD, 23040);
    apb_write(REG_THRESH, 0);
    apb_write(REG_BRIGHT, 20);
    send_item(0, 0, 0, 0);
    send_item(0, 1, 0, 1);
    send_item(1, 0, 0, 0);
    drain;

    apb_write(REG_SPREAD, 0);
    apb_write(REG_THRESH, 65535);
    apb_write(REG_BRIGHT, 0);
    send_item(0, 1, 0, 65535);
    send_item(1, 0, 0, 0);
    drain;

    apb_write(REG_SPREAD, 1500);
    apb_write(REG_THRESH, 20000);
    apb_write(REG_BRIGHT, 31);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
      end
      repeat (20) random_item;
    join
    drain;

    send_idle_pct = 13; recv_idle_pct = 76;
    repeat (140) random_item;
    drain;
    apb_write(REG_SPREAD, 4000);
    apb_write(REG_THRESH, 10000);
    apb_write(REG_BRIGHT, 5);
    send_idle_pct = 76; recv_idle_pct = 13;
    repeat (140) random_item;
    drain;
    apb_write(REG_SPREAD, 2500);
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (140) random_item;
    drain;

    if (errors == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
